FILE: design/srts_pkg.sv
// Shared types and constants for the shortest-remaining-time scheduler.
package srts_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;

   localparam logic OP_ARRIVE = 1'b0;
   localparam logic OP_DONE   = 1'b1;

   localparam int ENTRY_W = 88;

   typedef struct packed {
      logic [15:0] ident;
      logic [31:0] arrival;
      logic [15:0] total;
      logic [15:0] left;
      logic [7:0]  prio;
   } entry_type;

   typedef struct packed {
      logic        op;
      logic [15:0] proc_ident;
      logic [31:0] arrival_time;
      logic [15:0] burst_length;
      logic [7:0]  prio_level;
      logic [31:0] now_time;
   } req_type;

   typedef struct packed {
      logic [15:0] run_ident;
      logic [31:0] run_arrival;
      logic [15:0] run_total;
      logic [31:0] run_start;
      logic [31:0] run_end;
      logic [15:0] run_left;
      logic [7:0]  run_prio;
      logic        idle_flag;
      logic [4:0]  queue_fill;
      logic        drop_flag;
   } rsp_type;

endpackage

FILE: design/srts_if.sv
// Valid/ready channel interfaces for requests and responses.
interface srts_req_if;
   logic             valid;
   logic             ready;
   srts_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface srts_rsp_if;
   logic             valid;
   logic             ready;
   srts_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: design/srts_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module srts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

FILE: design/srts_front.sv
// Front end: two-entry request queue between the input channel and the engine.
module srts_front (
   input  logic              clock,
   input  logic              reset,
   srts_req_if.sink          req,
   output logic              item_valid,
   output srts_pkg::req_type item_data,
   input  logic              item_take
);
   srts_pkg::req_type buf_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push, pop;

   assign req.ready  = (cnt_ff != 2'd2);
   assign push       = req.valid && req.ready;
   assign item_valid = (cnt_ff != 2'd0);
   assign pop        = item_valid && item_take;
   assign item_data  = buf_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (push) buf_ff[wr_ff] <= req.data;
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
   end
endmodule

FILE: design/srts_engine.sv
// Back end: running process, ready queue memory and least-remaining scan.
module srts_engine #(
   parameter int QUEUE_DEPTH = srts_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  srts_pkg::req_type item_data,
   output logic              item_take,
   srts_rsp_if.source        rsp
);
   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_LAST  = 6'b000100,
      ST_FETCH = 6'b001000,
      ST_MOVE  = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type st_ff, st_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   srts_pkg::entry_type cur_ff, cur_in;
   logic [31:0]   start_ff, start_in;
   logic          drop_ff, drop_in;
   srts_pkg::req_type it_ff, it_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [AW-1:0] sel_ff, sel_in;
   logic [15:0]   best_ff, best_in;
   logic          rv_ff, rv_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   srts_pkg::entry_type wr_data, rd_data;

   srts_ram #(.WIDTH(srts_pkg::ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   logic [31:0] elapsed;
   logic [15:0] charged;
   logic        is_null, full;

   assign item_take = (st_ff == ST_IDLE) && !rv_ff;
   assign elapsed   = it_ff.now_time - start_ff;
   assign charged   = (elapsed >= {16'd0, cur_ff.left}) ? 16'd0
                      : 16'(cur_ff.left - elapsed[15:0]);
   assign full      = (cnt_ff == CW'(QUEUE_DEPTH));
   assign is_null   = (item_data.proc_ident == 16'd0) && (item_data.arrival_time == 32'd0)
                      && (item_data.burst_length == 16'd0) && (item_data.prio_level == 8'd0);

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; run_in = run_ff; cur_in = cur_ff;
      start_in = start_ff; drop_in = drop_ff; it_in = it_ff; idx_in = idx_ff;
      sel_in = sel_ff; best_in = best_ff; rv_in = rv_ff;
      wr_en = 1'b0; wr_addr = cnt_ff[AW-1:0]; wr_data = cur_ff;
      rd_addr = idx_ff[AW-1:0];
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (item_valid && item_take) begin
               it_in   = item_data;
               drop_in = 1'b0;
               if (item_data.op == srts_pkg::OP_ARRIVE) begin
                  if (is_null) begin
                     rv_in = 1'b1;
                  end else begin
                     st_in = ST_OUT;
                  end
               end else if (cnt_ff == '0) begin
                  run_in = 1'b0; cur_in = '0; start_in = '0; rv_in = 1'b1;
               end else begin
                  rd_addr = '0;
                  idx_in  = CW'(1);
                  sel_in  = '0;
                  best_in = 16'hFFFF;
                  st_in   = ST_SCAN;
               end
            end
         end
         ST_OUT: begin
            // arrival decision
            if (!run_ff) begin
               run_in = 1'b1;
               cur_in = '{it_ff.proc_ident, it_ff.arrival_time, it_ff.burst_length,
                          it_ff.burst_length, it_ff.prio_level};
               start_in = it_ff.now_time;
            end else if (cur_ff.left <= it_ff.burst_length) begin
               if (full) drop_in = 1'b1;
               else begin
                  wr_en = 1'b1;
                  wr_data = '{it_ff.proc_ident, it_ff.arrival_time, it_ff.burst_length,
                              it_ff.burst_length, it_ff.prio_level};
                  cnt_in = cnt_ff + CW'(1);
               end
            end else begin
               if (full) drop_in = 1'b1;
               else begin
                  wr_en = 1'b1;
                  wr_data = cur_ff;
                  wr_data.left = charged;
                  cnt_in = cnt_ff + CW'(1);
               end
               cur_in = '{it_ff.proc_ident, it_ff.arrival_time, it_ff.burst_length,
                          it_ff.burst_length, it_ff.prio_level};
               start_in = it_ff.now_time;
            end
            rv_in = 1'b1;
            st_in = ST_IDLE;
         end
         ST_SCAN: begin
            // rd_data holds entry idx_ff-1
            if (rd_data.left < best_ff) begin
               best_in = rd_data.left;
               sel_in  = AW'(idx_ff - CW'(1));
            end
            if (idx_ff == cnt_ff) begin
               rd_addr = AW'(cnt_ff - CW'(1));
               st_in   = ST_LAST;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_LAST: begin
            // rd_data is the last entry; park it, then fetch the winner
            cur_in  = rd_data;
            rd_addr = sel_ff;
            st_in   = ST_FETCH;
         end
         ST_FETCH: begin
            wr_en   = 1'b1;
            wr_addr = sel_ff;
            wr_data = cur_ff;
            cur_in  = rd_data;
            st_in   = ST_MOVE;
         end
         ST_MOVE: begin
            run_in   = 1'b1;
            start_in = it_ff.now_time;
            cnt_in   = cnt_ff - CW'(1);
            rv_in    = 1'b1;
            st_in    = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   assign rsp.valid = rv_ff;
   always_comb begin
      rsp.data.run_ident   = cur_ff.ident;
      rsp.data.run_arrival = cur_ff.arrival;
      rsp.data.run_total   = cur_ff.total;
      rsp.data.run_start   = start_ff;
      rsp.data.run_end     = start_ff + {16'd0, cur_ff.left};
      rsp.data.run_left    = cur_ff.left;
      rsp.data.run_prio    = cur_ff.prio;
      rsp.data.idle_flag   = !run_ff;
      rsp.data.queue_fill  = 5'(cnt_ff);
      rsp.data.drop_flag   = drop_ff;
   end

   always_ff @(posedge clock) begin
      it_ff <= it_in; idx_ff <= idx_in; sel_ff <= sel_in; best_ff <= best_in;
      if (reset) begin
         st_ff <= ST_IDLE; cnt_ff <= '0; run_ff <= 1'b0; cur_ff <= '0;
         start_ff <= '0; drop_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; run_ff <= run_in; cur_ff <= cur_in;
         start_ff <= start_in; drop_ff <= drop_in; rv_ff <= rv_in;
      end
   end
endmodule

FILE: design/shortest_remaining_time_scheduler.sv
// Shortest-remaining-time scheduler: request queue front end and scheduling engine.
// Arrival: the engine decides in the out state and then raises the response (a null arrival
// or an empty-queue completion responds straight from idle); a completion scans the N queued
// entries one per cycle over the ready queue memory read port, then passes the last, fetch and move states.
// Throughput: one item at a time in the engine; the front queue holds two more.
// Reset (synchronous, active high) empties both queues and marks the block idle.
module shortest_remaining_time_scheduler #(
   parameter int QUEUE_DEPTH = srts_pkg::QUEUE_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   srts_req_if.sink   req,
   srts_rsp_if.source rsp
);
   logic              item_valid, item_take;
   srts_pkg::req_type item_data;

   srts_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .item_valid(item_valid), .item_data(item_data), .item_take(item_take));

   srts_engine #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_engine (
      .clock(clock), .reset(reset),
      .item_valid(item_valid), .item_data(item_data), .item_take(item_take),
      .rsp(rsp));
endmodule

FILE: tb/tb_shortest_remaining_time_scheduler.sv
// Testbench for the shortest-remaining-time scheduler: directed and random traffic.
`timescale 1ns / 1ps

module tb_shortest_remaining_time_scheduler;

   localparam int DEPTH = srts_pkg::QUEUE_DEPTH_DEF;

   class sched_scoreboard;
      srts_pkg::entry_type slots[DEPTH];
      int                  fill;
      bit                  busy;
      srts_pkg::entry_type cur;
      logic [31:0]         cur_start;
      srts_pkg::rsp_type   pending[$];
      int                  errors;

      function void reset_state();
         fill = 0;
         busy = 0;
         cur = '0;
         cur_start = '0;
         pending.delete();
      endfunction

      function bit push_slot(srts_pkg::entry_type e);
         if (fill >= DEPTH) return 0;
         slots[fill] = e;
         fill++;
         return 1;
      endfunction

      function void note_request(srts_pkg::req_type r);
         srts_pkg::entry_type incoming;
         srts_pkg::entry_type held;
         logic [31:0]         elapsed;
         int                  sel;
         bit                  dropped;
         srts_pkg::rsp_type   o;
         dropped = 0;
         incoming = '{r.proc_ident, r.arrival_time, r.burst_length, r.burst_length,
                      r.prio_level};
         if (r.op == srts_pkg::OP_ARRIVE) begin
            if (r.proc_ident != 0 || r.arrival_time != 0 || r.burst_length != 0 ||
                r.prio_level != 0) begin
               if (!busy) begin
                  busy = 1; cur = incoming; cur_start = r.now_time;
               end else if (cur.left <= r.burst_length) begin
                  dropped = !push_slot(incoming);
               end else begin
                  // charge the preempted process, saturating at zero
                  elapsed = r.now_time - cur_start;
                  held = cur;
                  held.left = (elapsed >= {16'h0, cur.left}) ? 16'h0
                              : cur.left - elapsed[15:0];
                  dropped = !push_slot(held);
                  cur = incoming; cur_start = r.now_time;
               end
            end
         end else if (fill == 0) begin
            busy = 0; cur = '0; cur_start = '0;
         end else begin
            sel = 0;
            for (int i = 1; i < fill; i++)
               if (slots[i].left < slots[sel].left) sel = i;
            busy = 1; cur = slots[sel]; cur_start = r.now_time;
            slots[sel] = slots[fill - 1];
            fill--;
         end
         o.run_ident = cur.ident;
         o.run_arrival = cur.arrival;
         o.run_total = cur.total;
         o.run_start = cur_start;
         o.run_end = busy ? cur_start + {16'h0, cur.left} : 32'h0;
         o.run_left = cur.left;
         o.run_prio = cur.prio;
         o.idle_flag = !busy;
         o.queue_fill = fill[4:0];
         o.drop_flag = dropped;
         pending.push_back(o);
      endfunction

      task check_response(srts_pkg::rsp_type got);
         srts_pkg::rsp_type want;
         if (pending.size() == 0) begin
            report_error("response with nothing pending");
            return;
         end
         want = pending.pop_front();
         if (got.run_ident !== want.run_ident) report_error("run_ident");
         if (got.run_arrival !== want.run_arrival) report_error("run_arrival");
         if (got.run_total !== want.run_total) report_error("run_total");
         if (got.run_start !== want.run_start) report_error("run_start");
         if (got.run_end !== want.run_end) report_error("run_end");
         if (got.run_left !== want.run_left) report_error("run_left");
         if (got.run_prio !== want.run_prio) report_error("run_prio");
         if (got.idle_flag !== want.idle_flag) report_error("idle_flag");
         if (got.queue_fill !== want.queue_fill) report_error("queue_fill");
         if (got.drop_flag !== want.drop_flag) report_error("drop_flag");
      endtask

      task report_error(string what);
         errors++;
         $display("mismatch at %0t: %s", $realtime, what);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;

   srts_req_if req_ch();
   srts_rsp_if rsp_ch();

   shortest_remaining_time_scheduler dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source)
   );

   sched_scoreboard board = new();

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) board.note_request(req_ch.data);
         if (rsp_ch.valid && rsp_ch.ready) board.check_response(rsp_ch.data);
      end
   end

   // receiver stalls in stretches of random length
   initial begin
      int run_len;
      rsp_ch.ready = 0;
      @(negedge clock);
      forever begin
         run_len = $urandom_range(1, 20);
         rsp_ch.ready <= ($urandom_range(0, 3) != 0) || (run_len > 15);
         repeat (run_len) @(negedge clock);
         rsp_ch.ready <= $urandom_range(0, 1);
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   end

   logic [31:0] clock_now = 32'h0;
   int          burst_left = 0;

   task automatic send_item(srts_pkg::req_type r);
      // when a burst is over, valid is already low here; hold it low for a gap
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_ch.data <= r;
      req_ch.valid <= 1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      burst_left--;
      if (burst_left == 0) req_ch.valid <= 0;
   endtask

   task automatic send_fields(logic op, logic [15:0] id, logic [31:0] arr,
                              logic [15:0] burst, logic [7:0] pr, logic [31:0] now);
      srts_pkg::req_type r;
      r = '{op, id, arr, burst, pr, now};
      send_item(r);
   endtask

   task automatic drain_pending();
      if (burst_left != 0) req_ch.valid <= 0;
      burst_left = 0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   task automatic send_random();
      srts_pkg::req_type r;
      int                pick;
      pick = $urandom_range(0, 99);
      r.op = (pick < 45) ? srts_pkg::OP_DONE : srts_pkg::OP_ARRIVE;
      r.proc_ident = 16'($urandom);
      r.arrival_time = $urandom;
      r.burst_length = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                       : 16'($urandom_range(0, 200));
      r.prio_level = 8'($urandom);
      // mostly advance time; sometimes jump or go backwards
      case ($urandom_range(0, 9))
         0: clock_now = $urandom;
         1: clock_now = clock_now - $urandom_range(0, 50);
         default: clock_now = clock_now + $urandom_range(0, 100);
      endcase
      r.now_time = clock_now;
      if (pick >= 97) begin
         r.proc_ident = 0; r.arrival_time = 0; r.burst_length = 0; r.prio_level = 0;
      end
      send_item(r);
   endtask

   initial begin
      req_ch.valid = 0;
      req_ch.data = '0;
      board.errors = 0;
      board.reset_state();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: idle completion, null arrival, start, queue, preempt
      send_fields(srts_pkg::OP_DONE, 16'h0, 32'h0, 16'h0, 8'h0, 32'h0);
      send_fields(srts_pkg::OP_ARRIVE, 16'h0, 32'h0, 16'h0, 8'h0, 32'h5);
      send_fields(srts_pkg::OP_ARRIVE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF,
                  32'hFFFF_FFF0);
      send_fields(srts_pkg::OP_ARRIVE, 16'h0002, 32'h1, 16'hFFFF, 8'h01, 32'hFFFF_FFF8);
      send_fields(srts_pkg::OP_ARRIVE, 16'h0003, 32'h2, 16'h0010, 8'h80, 32'h0000_0010);
      send_fields(srts_pkg::OP_ARRIVE, 16'h0004, 32'h3, 16'h0001, 8'h00, 32'h0000_0000);
      send_fields(srts_pkg::OP_ARRIVE, 16'h0005, 32'h4, 16'h0000, 8'h7F, 32'h0000_1000);
      send_fields(srts_pkg::OP_DONE, 16'h0, 32'h0, 16'h0, 8'h0, 32'h0000_2000);
      send_fields(srts_pkg::OP_DONE, 16'h0, 32'h0, 16'h0, 8'h0, 32'hFFFF_FFFF);
      send_fields(srts_pkg::OP_ARRIVE, 16'h0006, 32'h0, 16'h0007, 8'h0, 32'h0);
      // fill the queue past its depth, then preempt with a full queue
      for (int i = 0; i < DEPTH + 2; i++)
         send_fields(srts_pkg::OP_ARRIVE, 16'(16'h100 + i), i, 16'hF000, 8'hAA, 32'h0);
      send_fields(srts_pkg::OP_ARRIVE, 16'h0200, 32'h9, 16'h0000, 8'h55, 32'h3);
      drain_pending();

      for (int n = 0; n < 550; n++) begin
         send_random();
         if (n == 275) drain_pending();
      end
      drain_pending();
      repeat (4 * DEPTH + 40) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end
endmodule
